/* hw/rtl/bdme_pkg.sv */
// Shared types, constants and helpers for the button debounce MIDI event block.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package bdme_pkg;

  // Default number of buttons that hold state.
  localparam int NUM_BUTTONS_DEF = 64;

  // Field widths.
  localparam int BTN_W  = 6;
  localparam int NOTE_W = 7;
  localparam int CH_W   = 5;
  localparam int VEL_W  = 7;
  localparam int KIND_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_CHANNEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_CHANNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_ON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_OFF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUE_NOTE_OFF   = 3'd4;

  localparam logic [CH_W-1:0]  RST_NOTE_CHANNEL    = 5'd1;
  localparam logic [CH_W-1:0]  RST_PROGRAM_CHANNEL = 5'd1;
  localparam logic [VEL_W-1:0] RST_VELOCITY_ON     = 7'd127;
  localparam logic [VEL_W-1:0] RST_VELOCITY_OFF    = 7'd0;
  localparam logic             RST_TRUE_NOTE_OFF   = 1'b1;

  // Message kind codes on the result channel.
  localparam logic [KIND_W-1:0] MSG_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] MSG_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] MSG_PROGRAM  = 2'd2;

  // Channel limits.
  localparam logic [CH_W-1:0] CH_MIN = 5'd1;
  localparam logic [CH_W-1:0] CH_MAX = 5'd16;

  // Event queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Events that the front hands to the back.
  typedef enum logic [1:0] {
    EV_NOTE_ON,
    EV_NOTE_RELEASE,
    EV_PROGRAM
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [NOTE_W-1:0] note;
  } msg_ev_t;

  // Per-button debounce state, changed by samples.
  typedef struct packed {
    logic [2:0] hist;
    logic       pressed;
    logic       last;
  } btn_dyn_t;

  // Per-button setup, changed by setup words.
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              latching;
    logic              program_mode;
  } btn_setup_t;

  // Out-of-range channel values are pinned to the legal range.
  function automatic logic [CH_W-1:0] clamp_channel(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] res;
    if (ch == '0) begin
      res = CH_MIN;
    end else if (ch > CH_MAX) begin
      res = CH_MAX;
    end else begin
      res = ch;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/bdme_queue.sv */
// Short event queue that decouples the front from the back.
// Depends on bdme_pkg for the event type and the queue depth.
`timescale 1ns / 1ps

module bdme_queue
  import bdme_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  msg_ev_t            push_data,
  input  logic               pop,
  output logic               q_valid,
  output msg_ev_t            q_data,
  output logic [Q_CNT_W-1:0] q_count
);

  msg_ev_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   head_r, head_nxt;
  logic [Q_PTR_W-1:0]   tail_r, tail_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  // Pointer and count updates.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

  assign q_valid = (count_r != '0);
  assign q_data  = slot_r[head_r];
  assign q_count = count_r;

endmodule

/* hw/rtl/bdme_front.sv */
// Front part: accepts input words, keeps per-button state and turns debounced
// transitions into events. Depends on bdme_pkg.
`timescale 1ns / 1ps

module bdme_front
  import bdme_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [BTN_W-1:0]   in_button,
  input  logic               in_level,
  input  logic [NOTE_W-1:0]  in_note,
  input  logic               in_latching,
  input  logic               in_program_mode,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               ev_push,
  output msg_ev_t            ev_data
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EXT_W = ((IDX_W > BTN_W) ? IDX_W : BTN_W) + 1;

  // State stores and their valid bits.
  btn_dyn_t   dyn_mem   [NUM_BUTTONS];
  btn_setup_t setup_mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] dyn_vld_r;
  logic [NUM_BUTTONS-1:0] setup_vld_r;

  // Second stage registers.
  logic              s1_valid_r;
  logic              s1_cmd_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_level_r;
  btn_setup_t        s1_setup_r;

  btn_dyn_t   dyn_q_r;
  btn_setup_t setup_q_r;
  logic       dyn_hit_r, setup_hit_r;
  logic       dyn_fwd_r, setup_fwd_r;
  btn_dyn_t   dyn_fwd_data_r;
  btn_setup_t setup_fwd_data_r;

  logic [EXT_W-1:0] btn_ext;
  logic [IDX_W-1:0] idx;
  logic             in_range;
  logic             accept;

  btn_dyn_t   cur_dyn, dyn_new;
  btn_setup_t cur_setup;
  logic [2:0] hist;
  logic       stable;
  logic       ev_valid;
  ev_kind_t   ev_kind;

  // Index decode and acceptance; room is kept for every word in flight.
  assign btn_ext  = EXT_W'(in_button);
  assign idx      = btn_ext[IDX_W-1:0];
  assign in_range = (btn_ext < EXT_W'(NUM_BUTTONS));
  assign in_ready = ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(s1_valid_r))
                    < (Q_CNT_W + 1)'(Q_DEPTH);
  assign accept   = in_valid && in_ready;

  // Stage one control: buttons outside the table are dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept && in_range;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r                <= in_cmd;
    s1_idx_r                <= idx;
    s1_level_r              <= in_level;
    s1_setup_r.note         <= in_note;
    s1_setup_r.latching     <= in_latching;
    s1_setup_r.program_mode <= in_program_mode;
  end

  // Registered reads, with bypass from the write that lands at the same edge.
  always_ff @(posedge clk) begin
    dyn_q_r          <= dyn_mem[idx];
    setup_q_r        <= setup_mem[idx];
    dyn_hit_r        <= dyn_vld_r[idx];
    setup_hit_r      <= setup_vld_r[idx];
    dyn_fwd_r        <= s1_valid_r && !s1_cmd_r && (s1_idx_r == idx);
    setup_fwd_r      <= s1_valid_r && s1_cmd_r && (s1_idx_r == idx);
    dyn_fwd_data_r   <= dyn_new;
    setup_fwd_data_r <= s1_setup_r;
  end

  // Current entry values; an entry never written reads as zero.
  always_comb begin
    if (dyn_fwd_r) begin
      cur_dyn = dyn_fwd_data_r;
    end else if (dyn_hit_r) begin
      cur_dyn = dyn_q_r;
    end else begin
      cur_dyn = '0;
    end
    if (setup_fwd_r) begin
      cur_setup = setup_fwd_data_r;
    end else if (setup_hit_r) begin
      cur_setup = setup_q_r;
    end else begin
      cur_setup = '0;
    end
  end

  // Debounce and event decision for one sample.
  always_comb begin
    hist     = {cur_dyn.hist[1:0], s1_level_r};
    stable   = (hist == 3'b000) || (hist == 3'b111);
    dyn_new  = cur_dyn;
    dyn_new.hist = hist;
    ev_valid = 1'b0;
    ev_kind  = EV_NOTE_ON;
    if (stable) begin
      dyn_new.last = s1_level_r;
      if (cur_setup.latching) begin
        // A latching button toggles on each new stable press.
        if (s1_level_r && !cur_dyn.last) begin
          ev_valid        = 1'b1;
          ev_kind         = cur_dyn.pressed ? EV_NOTE_RELEASE : EV_NOTE_ON;
          dyn_new.pressed = !cur_dyn.pressed;
        end
      end else if (s1_level_r) begin
        if (!cur_dyn.pressed) begin
          dyn_new.pressed = 1'b1;
          ev_valid        = 1'b1;
          ev_kind         = cur_setup.program_mode ? EV_PROGRAM : EV_NOTE_ON;
        end
      end else if (cur_dyn.pressed) begin
        // Program mode sends nothing on release.
        dyn_new.pressed = 1'b0;
        ev_valid        = !cur_setup.program_mode;
        ev_kind         = EV_NOTE_RELEASE;
      end
    end
  end

  assign ev_push      = s1_valid_r && !s1_cmd_r && ev_valid;
  assign ev_data.kind = ev_kind;
  assign ev_data.note = cur_setup.note;

  // Store writes.
  always_ff @(posedge clk) begin
    if (s1_valid_r && !s1_cmd_r) begin
      dyn_mem[s1_idx_r] <= dyn_new;
    end
    if (s1_valid_r && s1_cmd_r) begin
      setup_mem[s1_idx_r] <= s1_setup_r;
    end
  end

  // Valid bits stand in for clearing the stores at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dyn_vld_r   <= '0;
      setup_vld_r <= '0;
    end else if (s1_valid_r) begin
      if (s1_cmd_r) begin
        setup_vld_r[s1_idx_r] <= 1'b1;
      end else begin
        dyn_vld_r[s1_idx_r] <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/bdme_back.sv */
// Back part: holds the configuration registers and formats queued events into
// result words behind an output register. Depends on bdme_pkg.
`timescale 1ns / 1ps

module bdme_back
  import bdme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_valid,
  input  msg_ev_t               q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_message_kind,
  output logic [CH_W-1:0]       out_channel,
  output logic [NOTE_W-1:0]     out_data_one,
  output logic [VEL_W-1:0]      out_data_two
);

  logic [CH_W-1:0]  note_channel_r;
  logic [CH_W-1:0]  program_channel_r;
  logic [VEL_W-1:0] velocity_on_r;
  logic [VEL_W-1:0] velocity_off_r;
  logic             true_note_off_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [CH_W-1:0]   channel_r, channel_nxt;
  logic [NOTE_W-1:0] data_one_r;
  logic [VEL_W-1:0]  data_two_r, data_two_nxt;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_channel_r    <= RST_NOTE_CHANNEL;
      program_channel_r <= RST_PROGRAM_CHANNEL;
      velocity_on_r     <= RST_VELOCITY_ON;
      velocity_off_r    <= RST_VELOCITY_OFF;
      true_note_off_r   <= RST_TRUE_NOTE_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NOTE_CHANNEL:    note_channel_r    <= cfg_data[CH_W-1:0];
        CFG_PROGRAM_CHANNEL: program_channel_r <= cfg_data[CH_W-1:0];
        CFG_VELOCITY_ON:     velocity_on_r     <= cfg_data[VEL_W-1:0];
        CFG_VELOCITY_OFF:    velocity_off_r    <= cfg_data[VEL_W-1:0];
        CFG_TRUE_NOTE_OFF:   true_note_off_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Message formatting.
  always_comb begin
    case (q_data.kind)
      EV_NOTE_ON: begin
        kind_nxt     = MSG_NOTE_ON;
        channel_nxt  = clamp_channel(note_channel_r);
        data_two_nxt = velocity_on_r;
      end
      EV_NOTE_RELEASE: begin
        kind_nxt     = true_note_off_r ? MSG_NOTE_OFF : MSG_NOTE_ON;
        channel_nxt  = clamp_channel(note_channel_r);
        data_two_nxt = velocity_off_r;
      end
      EV_PROGRAM: begin
        kind_nxt     = MSG_PROGRAM;
        channel_nxt  = clamp_channel(program_channel_r);
        data_two_nxt = '0;
      end
      default: begin
        kind_nxt     = MSG_NOTE_ON;
        channel_nxt  = clamp_channel(note_channel_r);
        data_two_nxt = velocity_on_r;
      end
    endcase
  end

  // The output register refills in the cycle its word is taken.
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r     <= kind_nxt;
      channel_r  <= channel_nxt;
      data_one_r <= q_data.note;
      data_two_r <= data_two_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_message_kind = kind_r;
  assign out_channel      = channel_r;
  assign out_data_one     = data_one_r;
  assign out_data_two     = data_two_r;

endmodule

/* hw/rtl/button_debounce_midi_events_top.sv */
// Top level of the button debounce MIDI event block.
// Instantiates bdme_front, bdme_queue and bdme_back; depends on bdme_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid / in_ready    | in_cmd, in_button, in_level, in_note,
//            |                        | in_latching, in_program_mode
//   result   | out_valid / out_ready  | out_message_kind, out_channel,
//            |                        | out_data_one, out_data_two
//   config   | cfg_we                 | cfg_index, cfg_data
//
// One word is accepted per cycle while in_ready is high. A word passes through the
// state read-modify-write stage, then its event, if any, waits in a four-entry
// queue until the output register takes it in.
// in_ready drops only when the queue plus the word in flight fill it.
// Reset clears per-button valid bits at once, so there is no clearing pass.
`timescale 1ns / 1ps

module button_debounce_midi_events_top
  import bdme_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [BTN_W-1:0]      in_button,
  input  logic                  in_level,
  input  logic [NOTE_W-1:0]     in_note,
  input  logic                  in_latching,
  input  logic                  in_program_mode,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_message_kind,
  output logic [CH_W-1:0]       out_channel,
  output logic [NOTE_W-1:0]     out_data_one,
  output logic [VEL_W-1:0]      out_data_two,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               ev_push;
  msg_ev_t            ev_data;
  logic               q_valid;
  msg_ev_t            q_data;
  logic               q_pop;
  logic [Q_CNT_W-1:0] q_count;

  // Front: accept, debounce and classify.
  bdme_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_button       (in_button),
    .in_level        (in_level),
    .in_note         (in_note),
    .in_latching     (in_latching),
    .in_program_mode (in_program_mode),
    .q_count         (q_count),
    .ev_push         (ev_push),
    .ev_data         (ev_data)
  );

  // Event queue.
  bdme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_data),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  // Back: format and deliver.
  bdme_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_data           (q_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_message_kind (out_message_kind),
    .out_channel      (out_channel),
    .out_data_one     (out_data_one),
    .out_data_two     (out_data_two)
  );

endmodule
